>>> rtl/hapu_pkg.sv
// Shared types, register map and constant tables for the handheld sound mixer.
// Used by hapu_dp, hapu_ctrl and the top module; depends on nothing.
`timescale 1ns / 1ps

package hapu_pkg;

    localparam int WAVE_BYTES_DEF = 16;
    localparam int NREGS          = 23;
    localparam int RATE_W         = 12;
    localparam int IDX_W          = 6;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int PHASE_W        = 32;
    localparam int STEP_W         = 25;
    localparam int LEN_W          = 22;
    localparam int ENVC_W         = 19;
    localparam int SWPC_W         = 18;
    localparam int DIV_NUM_W      = 33;
    localparam int DIV_DEN_W      = 12;

    localparam logic [RATE_W-1:0] RATE_RST = 12'd48;
    localparam logic [7:0]        NR52_RST = 8'hF1;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODEL = 1'b1;

    // channel numbers
    localparam logic [1:0] CH_SQ1  = 2'd0;
    localparam logic [1:0] CH_SQ2  = 2'd1;
    localparam logic [1:0] CH_WAVE = 2'd2;

    // I/O addresses
    localparam logic [IDX_W-1:0] A_NR10 = 6'h10;
    localparam logic [IDX_W-1:0] A_NR12 = 6'h12;
    localparam logic [IDX_W-1:0] A_NR13 = 6'h13;
    localparam logic [IDX_W-1:0] A_NR14 = 6'h14;
    localparam logic [IDX_W-1:0] A_GAP1 = 6'h15;
    localparam logic [IDX_W-1:0] A_NR22 = 6'h17;
    localparam logic [IDX_W-1:0] A_NR23 = 6'h18;
    localparam logic [IDX_W-1:0] A_NR24 = 6'h19;
    localparam logic [IDX_W-1:0] A_NR30 = 6'h1A;
    localparam logic [IDX_W-1:0] A_NR33 = 6'h1D;
    localparam logic [IDX_W-1:0] A_NR34 = 6'h1E;
    localparam logic [IDX_W-1:0] A_GAP2 = 6'h1F;
    localparam logic [IDX_W-1:0] A_NR52 = 6'h26;

    // register file slots (address minus 0x10)
    localparam logic [4:0] R_NR10 = 5'd0;
    localparam logic [4:0] R_NR11 = 5'd1;
    localparam logic [4:0] R_NR12 = 5'd2;
    localparam logic [4:0] R_NR13 = 5'd3;
    localparam logic [4:0] R_NR14 = 5'd4;
    localparam logic [4:0] R_NR21 = 5'd6;
    localparam logic [4:0] R_NR22 = 5'd7;
    localparam logic [4:0] R_NR23 = 5'd8;
    localparam logic [4:0] R_NR24 = 5'd9;
    localparam logic [4:0] R_NR30 = 5'd10;
    localparam logic [4:0] R_NR31 = 5'd11;
    localparam logic [4:0] R_NR32 = 5'd12;
    localparam logic [4:0] R_NR33 = 5'd13;
    localparam logic [4:0] R_NR34 = 5'd14;
    localparam logic [4:0] R_NR50 = 5'd20;
    localparam logic [4:0] R_NR51 = 5'd21;
    localparam logic [4:0] R_NR52 = 5'd22;

    typedef struct packed {
        logic cfg_wr;
        logic wr;
        logic tick;
        logic mix_load;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic recalc_pend;
        logic div_done;
        logic div_busy;
        logic rate_zero;
    } t_stat;

    function automatic logic [7:0] reg_default(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:    v = 8'h80;
            5'd1:    v = 8'hBF;
            5'd2:    v = 8'hF3;
            5'd4:    v = 8'hBF;
            5'd6:    v = 8'h3F;
            5'd9:    v = 8'hBF;
            5'd10:   v = 8'h7F;
            5'd11:   v = 8'hFF;
            5'd12:   v = 8'h9F;
            5'd14:   v = 8'hBF;
            5'd16:   v = 8'hFF;
            5'd19:   v = 8'hBF;
            5'd20:   v = 8'h77;
            5'd21:   v = 8'hF3;
            5'd22:   v = 8'h70;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] wave_init(input logic color, input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0, 4'd12: v = 8'hac;
            4'd1, 4'd13: v = 8'hdd;
            4'd2, 4'd14: v = 8'hda;
            4'd3, 4'd15: v = 8'h48;
            4'd4:        v = 8'h36;
            4'd5:        v = 8'h02;
            4'd6:        v = 8'hcf;
            4'd7:        v = 8'h16;
            4'd8:        v = 8'h2c;
            4'd9:        v = 8'h04;
            4'd10:       v = 8'he5;
            4'd11:       v = 8'h2c;
            default:     v = 8'h00;
        endcase
        if (color) begin
            v = idx[0] ? 8'hFF : 8'h00;
        end
        return v;
    endfunction

    function automatic logic duty_high(input logic [1:0] duty, input logic [2:0] pos);
        logic [7:0] pat;
        case (duty)
            2'd0:    pat = 8'h04;
            2'd1:    pat = 8'h06;
            2'd2:    pat = 8'h0F;
            default: pat = 8'hF9;
        endcase
        return pat[pos];
    endfunction

endpackage

>>> rtl/hapu_div.sv
// Restoring divider, one quotient bit per cycle.
// Computes the channel phase steps; depends on nothing.
`timescale 1ns / 1ps

module hapu_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the numerator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> rtl/hapu_dp.sv
// Datapath: sound register file, wave RAM, channel counters, mixer, output register.
// Uses hapu_pkg and the serial divider hapu_div.
`timescale 1ns / 1ps

module hapu_dp import hapu_pkg::*; #(
    parameter int WAVE_BYTES = WAVE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic [IDX_W-1:0]           i_reg_index,
    input  logic [7:0]                 i_write_data,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [RATE_W-1:0]          i_cfg_data,
    output logic signed [SAMPLE_W-1:0] o_left,
    output logic signed [SAMPLE_W-1:0] o_right,
    output logic signed [SAMPLE_W-1:0] o_mono,
    output logic [2:0]                 o_chan_on
);

    localparam int WIDX_W = $clog2(WAVE_BYTES);
    localparam logic [7:0] NR12_DEF = reg_default(R_NR12);
    localparam logic [7:0] NR22_DEF = reg_default(R_NR22);

    logic [RATE_W-1:0]  r_rate,  n_rate;
    logic               r_color, n_color;
    logic [7:0]         r_regs  [NREGS],      n_regs  [NREGS];
    logic [7:0]         r_wave  [WAVE_BYTES], n_wave  [WAVE_BYTES];
    logic [PHASE_W-1:0] r_phase [3],          n_phase [3];
    logic [STEP_W-1:0]  r_step  [3],          n_step  [3];
    logic [LEN_W-1:0]   r_len   [3],          n_len   [3];
    logic [3:0]         r_vol   [2],          n_vol   [2];
    logic [ENVC_W-1:0]  r_envc  [2],          n_envc  [2];
    logic [SWPC_W-1:0]  r_swpc,  n_swpc;
    logic [10:0]        r_swpf,  n_swpf;
    logic [2:0]         r_active, n_active;
    logic [2:0]         r_recalc, n_recalc;
    logic [1:0]         r_div_ch, n_div_ch;
    logic signed [8:0]  r_mix_l, n_mix_l, r_mix_r, n_mix_r;
    logic signed [SAMPLE_W-1:0] r_out_l, r_out_r, r_out_m;
    logic [2:0]         r_out_on;

    // divider operands
    logic [1:0]           w_low, w_op_ch;
    logic [7:0]           w_lo, w_hi;
    logic [10:0]          w_freq;
    logic [DIV_DEN_W-1:0] w_den;
    logic [DIV_NUM_W-1:0] w_num, w_quot;
    logic [15:0]          w_thr;
    logic                 w_over, w_div_done, w_div_busy;
    logic                 w_pwr;
    logic [IDX_W-1:0]     w_off;

    // mixer
    logic signed [12:0]         w_lp, w_rp;
    logic signed [SAMPLE_W-1:0] w_left, w_right;
    logic signed [SAMPLE_W:0]   w_sum;

    assign w_low   = r_recalc[0] ? CH_SQ1 : (r_recalc[1] ? CH_SQ2 : CH_WAVE);
    assign w_op_ch = i_cmd.div_start ? w_low : r_div_ch;

    always_comb begin
        case (w_op_ch)
            CH_SQ1:  begin w_lo = r_regs[R_NR13]; w_hi = r_regs[R_NR14]; end
            CH_SQ2:  begin w_lo = r_regs[R_NR23]; w_hi = r_regs[R_NR24]; end
            default: begin w_lo = r_regs[R_NR33]; w_hi = r_regs[R_NR34]; end
        endcase
    end

    assign w_freq = {w_hi[2:0], w_lo};
    assign w_den  = 12'd2048 - {1'b0, w_freq};
    assign w_num  = (w_op_ch == CH_WAVE) ? {r_rate, 21'd0} : {4'd0, r_rate, 17'd0};
    assign w_thr  = (w_op_ch == CH_WAVE) ? {1'b0, w_den, 3'd0} : {w_den, 4'd0};
    assign w_over = {4'd0, r_rate} > w_thr;

    hapu_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_pwr = r_regs[R_NR52][7];
    assign w_off = i_reg_index - A_NR10;

    always_comb begin
        logic [7:0]          v_b;
        logic [1:0]          v_duty;
        logic                v_ctl;
        logic [7:0]          v_envr, v_lenr;
        logic [3:0]          v_s;
        logic signed [8:0]   v_sq, v_l, v_r, v_wx, v_w;
        logic [LEN_W-1:0]    v_lsum, v_lim;
        logic [17:0]         v_eper;
        logic [ENVC_W-1:0]   v_esum;
        logic [16:0]         v_sper;
        logic [SWPC_W-1:0]   v_ssum;
        logic [10:0]         v_delta;
        logic [11:0]         v_f;
        logic [7:0]          v_byte;
        logic [3:0]          v_nib;
        logic signed [4:0]   v_ws;
        logic [7:0]          v_pan;

        n_rate   = r_rate;
        n_color  = r_color;
        n_regs   = r_regs;
        n_wave   = r_wave;
        n_phase  = r_phase;
        n_step   = r_step;
        n_len    = r_len;
        n_vol    = r_vol;
        n_envc   = r_envc;
        n_swpc   = r_swpc;
        n_swpf   = r_swpf;
        n_active = r_active;
        n_recalc = r_recalc;
        n_div_ch = r_div_ch;
        n_mix_l  = r_mix_l;
        n_mix_r  = r_mix_r;
        v_b      = i_write_data;
        v_pan    = r_regs[R_NR51];
        v_l      = '0;
        v_r      = '0;
        v_duty   = '0;
        v_ctl    = 1'b0;
        v_envr   = '0;
        v_lenr   = '0;
        v_s      = '0;
        v_sq     = '0;
        v_lsum   = '0;
        v_lim    = '0;
        v_eper   = '0;
        v_esum   = '0;
        v_sper   = '0;
        v_ssum   = '0;
        v_delta  = '0;
        v_f      = '0;
        v_byte   = '0;
        v_nib    = '0;
        v_ws     = '0;
        v_wx     = '0;
        v_w      = '0;

        if (i_cmd.cfg_wr) begin
            case (i_cfg_index)
                CFG_RATE: begin
                    n_rate   = i_cfg_data;
                    n_recalc = '1;
                end
                default: begin
                    n_color = i_cfg_data[0];
                    for (int i = 0; i < WAVE_BYTES; i++) begin
                        n_wave[i] = wave_init(i_cfg_data[0], 4'(i));
                    end
                end
            endcase
        end

        // with power off only the master register takes a write
        if (i_cmd.wr && (w_pwr || i_reg_index == A_NR52)) begin
            if (i_reg_index[5:4] == 2'b11) begin
                if (!r_active[CH_WAVE]) begin
                    n_wave[i_reg_index[WIDX_W-1:0]] = v_b;
                end
            end else if (i_reg_index >= A_NR10 && i_reg_index <= A_NR52 &&
                         i_reg_index != A_GAP1 && i_reg_index != A_GAP2) begin
                n_regs[w_off[4:0]] = v_b;
                case (i_reg_index)
                    A_NR10: n_swpf = {r_regs[R_NR14][2:0], r_regs[R_NR13]};
                    A_NR12: n_vol[0] = v_b[7:4];
                    A_NR13: n_recalc[CH_SQ1] = 1'b1;
                    A_NR14: begin
                        n_recalc[CH_SQ1] = 1'b1;
                        if (v_b[7]) begin
                            n_swpc = '0;
                            n_swpf = {v_b[2:0], r_regs[R_NR13]};
                            n_vol[0] = r_regs[R_NR12][7:4];
                            if (!r_active[CH_SQ1]) begin
                                n_phase[CH_SQ1] = '0;
                            end
                            n_active[CH_SQ1] = 1'b1;
                            n_len[CH_SQ1]    = '0;
                            n_envc[0]        = '0;
                        end
                    end
                    A_NR22: n_vol[1] = v_b[7:4];
                    A_NR23: n_recalc[CH_SQ2] = 1'b1;
                    A_NR24: begin
                        n_recalc[CH_SQ2] = 1'b1;
                        if (v_b[7]) begin
                            n_vol[1] = r_regs[R_NR22][7:4];
                            if (!r_active[CH_SQ2]) begin
                                n_phase[CH_SQ2] = '0;
                            end
                            n_active[CH_SQ2] = 1'b1;
                            n_len[CH_SQ2]    = '0;
                            n_envc[1]        = '0;
                        end
                    end
                    A_NR30: begin
                        if (!v_b[7]) begin
                            n_active[CH_WAVE] = 1'b0;
                        end
                    end
                    A_NR33: n_recalc[CH_WAVE] = 1'b1;
                    A_NR34: begin
                        n_recalc[CH_WAVE] = 1'b1;
                        if (v_b[7]) begin
                            if (!r_active[CH_WAVE]) begin
                                n_phase[CH_WAVE] = '0;
                            end
                            n_len[CH_WAVE]    = '0;
                            n_active[CH_WAVE] = r_regs[R_NR30][7];
                        end
                    end
                    A_NR52: begin
                        if (!v_b[7]) begin
                            // power down: defaults back, channel state cleared
                            for (int i = 0; i < NREGS; i++) begin
                                n_regs[i] = reg_default(5'(i));
                            end
                            for (int c = 0; c < 3; c++) begin
                                n_phase[c] = '0;
                                n_len[c]   = '0;
                            end
                            n_envc[0] = '0;
                            n_envc[1] = '0;
                            n_vol[0]  = NR12_DEF[7:4];
                            n_vol[1]  = NR22_DEF[7:4];
                            n_swpc    = '0;
                            n_swpf    = '0;
                            n_active  = '0;
                            n_recalc  = '1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (i_cmd.tick) begin
            for (int c = 0; c < 2; c++) begin
                v_duty = (c == 0) ? r_regs[R_NR11][7:6] : r_regs[R_NR21][7:6];
                v_ctl  = (c == 0) ? r_regs[R_NR14][6]   : r_regs[R_NR24][6];
                v_envr = (c == 0) ? r_regs[R_NR12]      : r_regs[R_NR22];
                v_lenr = (c == 0) ? r_regs[R_NR11]      : r_regs[R_NR21];
                if (r_active[c]) begin
                    v_s  = duty_high(v_duty, r_phase[c][20:18]) ? r_vol[c] : 4'd0;
                    v_sq = $signed({3'd0, v_s, 2'd0});
                    n_phase[c] = r_phase[c] + PHASE_W'(r_step[c]);
                    if (v_ctl) begin
                        v_lsum   = r_len[c] + LEN_W'(r_rate);
                        v_lim    = LEN_W'({7'd64 - {1'b0, v_lenr[5:0]}, 13'd0});
                        n_len[c] = v_lsum;
                        if (v_lsum >= v_lim) begin
                            n_active[c] = 1'b0;
                        end
                    end
                    v_eper = {v_envr[2:0], 15'd0};
                    if (v_eper != '0) begin
                        v_esum = r_envc[c] + ENVC_W'(r_rate);
                        if (v_esum >= ENVC_W'(v_eper)) begin
                            n_envc[c] = v_esum - ENVC_W'(v_eper);
                            if (v_envr[3]) begin
                                if (r_vol[c] != 4'hF) begin
                                    n_vol[c] = r_vol[c] + 4'd1;
                                end
                            end else if (r_vol[c] != 4'h0) begin
                                n_vol[c] = r_vol[c] - 4'd1;
                            end
                        end else begin
                            n_envc[c] = v_esum;
                        end
                    end
                    if (v_pan[c]) begin
                        v_r = v_r + v_sq;
                    end
                    if (v_pan[c+4]) begin
                        v_l = v_l + v_sq;
                    end
                end
            end

            // frequency sweep on square 1
            v_sper = {r_regs[R_NR10][6:4], 14'd0};
            if (r_active[CH_SQ1] && v_sper != '0) begin
                v_ssum = r_swpc + SWPC_W'(r_rate);
                if (v_ssum >= SWPC_W'(v_sper)) begin
                    n_swpc  = v_ssum - SWPC_W'(v_sper);
                    v_delta = r_swpf >> r_regs[R_NR10][2:0];
                    v_f     = r_regs[R_NR10][3] ? {1'b0, r_swpf} - {1'b0, v_delta}
                                                : {1'b0, r_swpf} + {1'b0, v_delta};
                    if (v_f[11]) begin
                        n_active[CH_SQ1] = 1'b0;
                    end else begin
                        n_swpf           = v_f[10:0];
                        n_regs[R_NR13]   = v_f[7:0];
                        n_regs[R_NR14]   = {r_regs[R_NR14][7:3], v_f[10:8]};
                        n_recalc[CH_SQ1] = 1'b1;
                    end
                end else begin
                    n_swpc = v_ssum;
                end
            end

            if (r_active[CH_WAVE]) begin
                v_byte = r_wave[r_phase[CH_WAVE][22 +: WIDX_W]];
                v_nib  = r_phase[CH_WAVE][21] ? v_byte[3:0] : v_byte[7:4];
                v_ws   = $signed({1'b0, v_nib}) - 5'sd8;
                v_wx   = {{4{v_ws[4]}}, v_ws};
                case (r_regs[R_NR32][6:5])
                    2'd1:    v_w = v_wx <<< 2;
                    2'd2:    v_w = v_wx <<< 1;
                    2'd3:    v_w = v_wx;
                    default: v_w = '0;
                endcase
                n_phase[CH_WAVE] = r_phase[CH_WAVE] + PHASE_W'(r_step[CH_WAVE]);
                if (r_regs[R_NR34][6]) begin
                    v_lsum = r_len[CH_WAVE] + LEN_W'(r_rate);
                    v_lim  = {9'd256 - {1'b0, r_regs[R_NR31]}, 13'd0};
                    n_len[CH_WAVE] = v_lsum;
                    if (v_lsum >= v_lim) begin
                        n_active[CH_WAVE] = 1'b0;
                    end
                end
                if (v_pan[2]) begin
                    v_r = v_r + v_w;
                end
                if (v_pan[6]) begin
                    v_l = v_l + v_w;
                end
            end
            n_mix_l = v_l;
            n_mix_r = v_r;
        end

        if (i_cmd.div_start) begin
            n_div_ch = w_low;
        end
        if (w_div_done) begin
            n_step[r_div_ch]   = w_over ? '0 : w_quot[STEP_W-1:0];
            n_recalc[r_div_ch] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RST;
            r_color  <= 1'b0;
            for (int i = 0; i < NREGS; i++) begin
                r_regs[i] <= reg_default(5'(i));
            end
            r_regs[R_NR52] <= NR52_RST;
            for (int i = 0; i < WAVE_BYTES; i++) begin
                r_wave[i] <= wave_init(1'b0, 4'(i));
            end
            for (int c = 0; c < 3; c++) begin
                r_phase[c] <= '0;
                r_step[c]  <= '0;
                r_len[c]   <= '0;
            end
            r_vol[0]  <= NR12_DEF[7:4];
            r_vol[1]  <= NR22_DEF[7:4];
            r_envc[0] <= '0;
            r_envc[1] <= '0;
            r_swpc    <= '0;
            r_swpf    <= '0;
            r_active  <= '0;
            r_recalc  <= '1;
            r_div_ch  <= CH_SQ1;
        end else begin
            r_rate   <= n_rate;
            r_color  <= n_color;
            r_regs   <= n_regs;
            r_wave   <= n_wave;
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_len    <= n_len;
            r_vol    <= n_vol;
            r_envc   <= n_envc;
            r_swpc   <= n_swpc;
            r_swpf   <= n_swpf;
            r_active <= n_active;
            r_recalc <= n_recalc;
            r_div_ch <= n_div_ch;
        end
    end

    // master volume and output register
    assign w_lp    = r_mix_l * $signed({1'b0, r_regs[R_NR50][6:4]});
    assign w_rp    = r_mix_r * $signed({1'b0, r_regs[R_NR50][2:0]});
    assign w_left  = {w_lp[11:0], 4'd0};
    assign w_right = {w_rp[11:0], 4'd0};
    assign w_sum   = {w_left[SAMPLE_W-1], w_left} + {w_right[SAMPLE_W-1], w_right};

    always_ff @(posedge i_clk) begin
        r_mix_l <= n_mix_l;
        r_mix_r <= n_mix_r;
        if (i_cmd.mix_load) begin
            r_out_l  <= w_left;
            r_out_r  <= w_right;
            r_out_m  <= w_sum[SAMPLE_W:1];
            r_out_on <= r_active;
        end
    end

    assign o_left    = r_out_l;
    assign o_right   = r_out_r;
    assign o_mono    = r_out_m;
    assign o_chan_on = r_out_on;

    assign o_stat.recalc_pend = (r_recalc != '0);
    assign o_stat.div_done    = w_div_done;
    assign o_stat.div_busy    = w_div_busy;
    assign o_stat.rate_zero   = (r_rate == '0);

endmodule

>>> rtl/hapu_ctrl.sv
// Controller: sequences writes, ticks, output loads and phase step recomputes.
// Uses hapu_pkg; drives hapu_dp through t_cmd and watches t_stat.
`timescale 1ns / 1ps

module hapu_ctrl import hapu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_req_type,
    output logic  o_in_ready,
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MIX   = 4'b0010,
        S_CHECK = 4'b0100,
        S_DIV   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc, w_cfg_acc;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    o_cmd.cfg_wr = 1'b1;
                    n_state      = S_CHECK;
                end else if (w_in_acc) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.wr = 1'b1;
                        n_state  = S_CHECK;
                    end else if (!i_stat.rate_zero) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_MIX;
                    end
                end
            end
            S_MIX: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.mix_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.recalc_pend) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CHECK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/handheld_apu_sample_mixer_top.sv
// Handheld sound mixer: two square channels and a wave channel, one mixed sample per tick
// while the rate is not zero. A register write that changes a pitch register runs one phase
// step recompute; a tick does so when the sweep changes square 1's pitch (33-step serial
// divider). A power-off write and a rate write run three recomputes. Output is registered;
// the next item is taken while a sample waits. After reset (synchronous, i_rst_n low) the
// block runs three recomputes before it accepts an item.
`timescale 1ns / 1ps

module handheld_apu_sample_mixer_top import hapu_pkg::*; #(
    parameter int WAVE_BYTES = WAVE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [5:0] reg_index, [13:6] write_data
    input  logic [0:0]           s_axis_tuser,  // [0] req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,  // [15:0] left, [31:16] right,
                                                // [47:32] mono, [50:48] channels_on
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic signed [SAMPLE_W-1:0] w_left, w_right, w_mono;
    logic [2:0] w_chan_on;

    hapu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    hapu_dp #(
        .WAVE_BYTES (WAVE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_reg_index  (s_axis_tdata[5:0]),
        .i_write_data (s_axis_tdata[13:6]),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_left       (w_left),
        .o_right      (w_right),
        .o_mono       (w_mono),
        .o_chan_on    (w_chan_on)
    );

    assign m_axis_tdata = {5'd0, w_chan_on, w_mono, w_right, w_left};

    a_one_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready && i_cfg_valid && o_cfg_ready))
        else $error("input and configuration transactions in the same cycle");

    a_ready_no_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_stat.recalc_pend && !w_stat.div_busy)
        else $error("input ready while a phase step recompute is pending");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> $past(w_stat.div_busy))
        else $error("divider done without a running division");

endmodule
